### rtl/core/bpb_pkg.sv
// shared constants, types and command structs for the page byte packer
package bpb_pkg;

	localparam int MAX_PAGES   = 8;
	localparam int MAX_COLUMNS = 128;
	localparam int STORE_DEPTH = MAX_PAGES * MAX_COLUMNS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int PAGE_W = 3;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 6;
	localparam int BYTE_W = 8;
	localparam int BIT_W  = 3;
	localparam int PCNT_W = 4;
	localparam int CCNT_W = 8;
	localparam int CFG_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [PCNT_W-1:0] PAGE_COUNT_RST   = PCNT_W'(MAX_PAGES);
	localparam logic [CCNT_W-1:0] COLUMN_COUNT_RST = CCNT_W'(MAX_COLUMNS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAGE_COUNT   = 2'd0,
		REG_COLUMN_COUNT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ
	} ctrl_state_t;

	typedef struct packed {
		logic clear;   // write zero at the sweep address
		logic accept;  // take an item and latch its address
		logic commit;  // write back the updated byte
		logic load;    // move the fetched byte to the output
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/core/bpb_in_if.sv
// input channel: pixel writes and byte requests
interface bpb_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic pixel;

	modport source (output valid, output kind, output pixel, input ready);
	modport sink (input valid, input kind, input pixel, output ready);
endinterface

### rtl/core/bpb_out_if.sv
// output channel: packed bytes with their page and column
interface bpb_out_if;
	import bpb_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packed_byte;
	logic [PAGE_W-1:0] page_index;
	logic [COL_W-1:0]  column_index;
	logic              frame_last;

	modport source (output valid, output packed_byte, output page_index,
		output column_index, output frame_last, input ready);
	modport sink (input valid, input packed_byte, input page_index,
		input column_index, input frame_last, output ready);
endinterface

### rtl/core/bitmap_to_page_bytes_top.sv
// top level of the bitmap to lcd page byte packer
// Takes a row-major monochrome bitmap one pixel per write item and keeps it in a
// 1024-byte store in lcd page format (bit 0 = top row of the page); a read item
// returns the next byte in page-major order with its page, column and an end of
// frame mark. The store has one registered read port, so a pixel write is a
// read-modify-write and a byte read waits for the registered store data. A read
// item holds the block until the output register is free; the output register lets
// the next item be taken while a byte waits. After reset the store is cleared by a
// sweep over every address during which no item is taken; register writes are
// accepted at any time and must only be made while idle.
module bitmap_to_page_bytes_top (
	input  logic                          clk,
	input  logic                          arst_n,
	bpb_in_if.sink                        in_ch,
	bpb_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [bpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpb_pkg::CFG_W-1:0]     cfg_data
);
	import bpb_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	bpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_kind    (in_ch.kind),
		.in_pixel   (in_ch.pixel),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_byte   (out_ch.packed_byte),
		.out_page   (out_ch.page_index),
		.out_column (out_ch.column_index),
		.out_last   (out_ch.frame_last)
	);
endmodule

### rtl/core/bpb_ram.sv
// generic simple dual port ram with registered read
module bpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/bpb_ctrl.sv
// controller state machine: clear sweep, item accept, write back and output load
module bpb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_kind,
	output logic                in_ready,
	input  bpb_pkg::dp_status_t status,
	output bpb_pkg::dp_cmd_t    cmd
);
	import bpb_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = (in_kind == KIND_READ) ? ST_READ : ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_READ: begin
				// hold until the output register can take the byte
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end
endmodule

### rtl/core/bpb_dp.sv
// datapath: config registers, frame counters, byte store and output register
module bpb_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bpb_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_kind,
	input  logic                              in_pixel,
	input  bpb_pkg::dp_cmd_t                  cmd,
	output bpb_pkg::dp_status_t               status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bpb_pkg::BYTE_W-1:0]        out_byte,
	output logic [bpb_pkg::PAGE_W-1:0]        out_page,
	output logic [bpb_pkg::COL_W-1:0]         out_column,
	output logic                              out_last
);
	import bpb_pkg::*;

	localparam int ROWS_W = ROW_W + 1;

	logic [PCNT_W-1:0] page_count_q;
	logic [CCNT_W-1:0] column_count_q;
	logic [ROW_W-1:0]  write_row_q;
	logic [COL_W-1:0]  write_column_q;
	logic [PAGE_W-1:0] read_page_q;
	logic [COL_W-1:0]  read_column_q;
	logic [ADDR_W-1:0] clr_q;

	logic [ADDR_W-1:0] addr_q;
	logic [BIT_W-1:0]  bit_q;
	logic              pixel_q;
	logic [PAGE_W-1:0] page_q;
	logic [COL_W-1:0]  col_q;
	logic              last_q;

	logic [PCNT_W-1:0] pages;
	logic [CCNT_W-1:0] cols;
	logic [ROWS_W-1:0] rows;

	logic [ROW_W-1:0]  wr_row;
	logic [COL_W-1:0]  wr_col;
	logic [ROW_W-1:0]  wr_row_nx;
	logic [COL_W-1:0]  wr_col_nx;
	logic [PAGE_W-1:0] rd_page;
	logic [COL_W-1:0]  rd_col;
	logic [PAGE_W-1:0] rd_page_nx;
	logic [COL_W-1:0]  rd_col_nx;
	logic              rd_last;
	logic              wr_col_end;
	logic              rd_col_end;

	logic [PAGE_W-1:0] acc_page;
	logic [COL_W-1:0]  acc_col;
	logic [ADDR_W-1:0] acc_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [BYTE_W-1:0] bit_mask;

	// frame in use, with out-of-range counts clamped
	always_comb begin
		pages = page_count_q;
		if (pages == '0) begin
			pages = PCNT_W'(1);
		end else if (pages > PCNT_W'(MAX_PAGES)) begin
			pages = PCNT_W'(MAX_PAGES);
		end
		cols = column_count_q;
		if (cols == '0) begin
			cols = CCNT_W'(1);
		end else if (cols > CCNT_W'(MAX_COLUMNS)) begin
			cols = CCNT_W'(MAX_COLUMNS);
		end
		rows = ROWS_W'({pages, 3'b000});
	end

	// counters left beyond a shrunken frame restart at zero
	always_comb begin
		wr_row  = (ROWS_W'(write_row_q) >= rows) ? '0 : write_row_q;
		wr_col  = (CCNT_W'(write_column_q) >= cols) ? '0 : write_column_q;
		rd_page = (PCNT_W'(read_page_q) >= pages) ? '0 : read_page_q;
		rd_col  = (CCNT_W'(read_column_q) >= cols) ? '0 : read_column_q;

		wr_col_end = (CCNT_W'(wr_col) + CCNT_W'(1)) >= cols;
		wr_col_nx  = wr_col_end ? '0 : wr_col + COL_W'(1);
		wr_row_nx  = wr_row;
		if (wr_col_end) begin
			wr_row_nx = ((ROWS_W'(wr_row) + ROWS_W'(1)) >= rows) ? '0 : wr_row + ROW_W'(1);
		end

		rd_col_end = (CCNT_W'(rd_col) + CCNT_W'(1)) >= cols;
		rd_col_nx  = rd_col_end ? '0 : rd_col + COL_W'(1);
		rd_page_nx = rd_page;
		if (rd_col_end) begin
			rd_page_nx = ((PCNT_W'(rd_page) + PCNT_W'(1)) >= pages) ? '0
				: rd_page + PAGE_W'(1);
		end
		rd_last = rd_col_end && ((PCNT_W'(rd_page) + PCNT_W'(1)) == pages);

		if (in_kind == KIND_READ) begin
			acc_page = rd_page;
			acc_col  = rd_col;
		end else begin
			acc_page = wr_row[ROW_W-1:BIT_W];
			acc_col  = wr_col;
		end
		acc_addr = ADDR_W'(acc_page) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(acc_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_count_q   <= PAGE_COUNT_RST;
			column_count_q <= COLUMN_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAGE_COUNT:   page_count_q   <= cfg_data[PCNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= cfg_data[CCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_row_q    <= '0;
			write_column_q <= '0;
			read_page_q    <= '0;
			read_column_q  <= '0;
			clr_q          <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.accept) begin
				if (in_kind == KIND_READ) begin
					read_page_q   <= rd_page_nx;
					read_column_q <= rd_col_nx;
				end else begin
					write_row_q    <= wr_row_nx;
					write_column_q <= wr_col_nx;
				end
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q  <= acc_addr;
			bit_q   <= wr_row[BIT_W-1:0];
			pixel_q <= in_pixel;
			page_q  <= acc_page;
			col_q   <= acc_col;
			last_q  <= rd_last;
		end
	end

	assign status.clear_done = (clr_q == ADDR_W'(STORE_DEPTH - 1));
	assign status.out_free   = !out_valid || out_ready;

	// read address is presented at accept so the registered byte is ready in the next state
	assign ram_raddr = cmd.accept ? acc_addr : addr_q;
	assign bit_mask  = BYTE_W'(1) << bit_q;

	always_comb begin
		ram_we    = cmd.clear || cmd.commit;
		ram_waddr = cmd.clear ? clr_q : addr_q;
		if (cmd.clear) begin
			ram_wdata = '0;
		end else if (pixel_q) begin
			ram_wdata = ram_rdata | bit_mask;
		end else begin
			ram_wdata = ram_rdata & ~bit_mask;
		end
	end

	bpb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte   <= ram_rdata;
			out_page   <= page_q;
			out_column <= col_q;
			out_last   <= last_q;
		end
	end
endmodule

### dv/tb_bitmap_to_page_bytes_top.sv
// testbench for the bitmap to lcd page byte packer: stimulus, byte predictor and checks
`timescale 1ns / 100ps

module tb_bitmap_to_page_bytes_top;
	import bpb_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	localparam int QUIET_LIMIT = 5000;   // covers the clear sweep and the long hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int FRAME_ITEMS_MAX = 200;

	// indexes past the register list, writes to them are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] packed_byte;
		logic [PAGE_W-1:0] page_index;
		logic [COL_W-1:0]  column_index;
		logic              frame_last;
	} page_byte_t;

	class page_byte_scoreboard;
		logic [BYTE_W-1:0] byte_store [STORE_DEPTH];
		logic [PCNT_W-1:0] page_count;
		logic [CCNT_W-1:0] column_count;
		int unsigned       write_row, write_column, read_page, read_column;
		page_byte_t        expected_bytes [$];
		int unsigned       error_count;

		function new();
			foreach (byte_store[i])
				byte_store[i] = '0;
			page_count = PAGE_COUNT_RST;
			column_count = COLUMN_COUNT_RST;
			write_row = 0;
			write_column = 0;
			read_page = 0;
			read_column = 0;
			error_count = 0;
		endfunction

		function int unsigned pages_used();
			if (page_count == 0)
				return 1;
			if (page_count > MAX_PAGES)
				return MAX_PAGES;
			return page_count;
		endfunction

		function int unsigned columns_used();
			if (column_count == 0)
				return 1;
			if (column_count > MAX_COLUMNS)
				return MAX_COLUMNS;
			return column_count;
		endfunction

		function int unsigned pending();
			return expected_bytes.size();
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
			case (index)
				REG_PAGE_COUNT: page_count = data[PCNT_W-1:0];
				REG_COLUMN_COUNT: column_count = data[CCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(item_kind_t kind, logic pixel);
			int unsigned pages, cols, rows, addr;
			page_byte_t  b;
			pages = pages_used();
			cols = columns_used();
			rows = pages * 8;
			if (kind == KIND_WRITE) begin
				// a shrunk frame can leave counters outside it
				if (write_row >= rows)
					write_row = 0;
				if (write_column >= cols)
					write_column = 0;
				addr = (write_row / 8) * MAX_COLUMNS + write_column;
				byte_store[addr][write_row % 8] = pixel;
				write_column++;
				if (write_column >= cols) begin
					write_column = 0;
					write_row++;
					if (write_row >= rows)
						write_row = 0;
				end
			end else begin
				if (read_page >= pages)
					read_page = 0;
				if (read_column >= cols)
					read_column = 0;
				addr = read_page * MAX_COLUMNS + read_column;
				b.packed_byte = byte_store[addr];
				b.page_index = PAGE_W'(read_page);
				b.column_index = COL_W'(read_column);
				b.frame_last = (read_page == pages - 1) && (read_column == cols - 1);
				expected_bytes.push_back(b);
				read_column++;
				if (read_column >= cols) begin
					read_column = 0;
					read_page++;
					if (read_page >= pages)
						read_page = 0;
				end
			end
		endfunction

		function void compare_field(string field, logic [BYTE_W-1:0] want,
				logic [BYTE_W-1:0] got);
			if (got !== want) begin
				error_count++;
				$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			end
		endfunction

		function void check_byte(page_byte_t got);
			page_byte_t want;
			if (expected_bytes.size() == 0) begin
				error_count++;
				$display("%0t: byte with nothing expected, got %p", $time, got);
				return;
			end
			want = expected_bytes.pop_front();
			compare_field("packed_byte", want.packed_byte, got.packed_byte);
			compare_field("page_index", want.page_index, got.page_index);
			compare_field("column_index", want.column_index, got.column_index);
			compare_field("frame_last", want.frame_last, got.frame_last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	bpb_in_if in_ch();
	bpb_out_if out_ch();

	page_byte_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	bitmap_to_page_bytes_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		page_byte_t got;
		bit moved;
		moved = 1'b0;
		if (out_ch.valid && out_ch.ready) begin
			got.packed_byte = out_ch.packed_byte;
			got.page_index = out_ch.page_index;
			got.column_index = out_ch.column_index;
			got.frame_last = out_ch.frame_last;
			sb.check_byte(got);
			moved = 1'b1;
		end
		if (in_ch.valid && in_ch.ready) begin
			sb.note_item(item_kind_t'(in_ch.kind), in_ch.pixel);
			moved = 1'b1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_bitmap_to_page_bytes_top: errors");
			$finish;
		end
	end

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input item_kind_t kind, input logic pixel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.pixel <= pixel;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		// a trailing pixel write may still be in the store pipeline
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		sb.set_register(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [CFG_W-1:0] pages_data, input logic [CFG_W-1:0] cols_data,
			input int items, input int send_pct, input int recv_pct, input bit hold);
		int sent, frame_px, frame_bytes, k;
		drain();
		write_reg(REG_PAGE_COUNT, pages_data);
		write_reg(REG_COLUMN_COUNT, cols_data);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (hold)
			hold_req = 1'b1;
		frame_px = sb.pages_used() * 8 * sb.columns_used();
		frame_bytes = sb.pages_used() * sb.columns_used();
		sent = 0;
		while (sent < items) begin
			if (frame_px + frame_bytes <= FRAME_ITEMS_MAX && $urandom_range(9) < 8) begin
				// whole frame of random pixels, then read it all back
				repeat (frame_px) send_item(KIND_WRITE, 1'($urandom_range(1)));
				repeat (frame_bytes) send_item(KIND_READ, 1'($urandom_range(1)));
				sent += frame_px + frame_bytes;
			end else begin
				k = $urandom_range(12, 1);
				repeat (k) send_item(item_kind_t'($urandom_range(1)), 1'($urandom_range(1)));
				sent += k;
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_WRITE;
		in_ch.pixel = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PAGE_COUNT;
		cfg_data = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default frame: read of a cleared byte with pixel set, then three pixels and two reads
		send_item(KIND_READ, 1'b1);
		send_item(KIND_WRITE, 1'b1);
		send_item(KIND_WRITE, 1'b0);
		send_item(KIND_WRITE, 1'b1);
		send_item(KIND_READ, 1'b0);
		send_item(KIND_READ, 1'b1);
		drain();
		write_reg(REG_SPARE_A, 8'hAA);
		write_reg(REG_SPARE_B, 8'h55);
		// zero page count acts as one, counters left outside the frame restart
		write_reg(REG_PAGE_COUNT, 8'h10);
		write_reg(REG_COLUMN_COUNT, 8'h02);
		for (int i = 0; i < 16; i++)
			send_item(KIND_WRITE, (i % 3) != 0);
		repeat (3) send_item(KIND_READ, 1'b0);

		run_phase(8'h01, 8'h04, 200, 0, 0, 1'b0);
		run_phase(8'h02, 8'h03, 200, 70, 0, 1'b0);
		run_phase(8'h08, 8'h01, 200, 0, 70, 1'b0);
		run_phase(8'h01, 8'h80, 300, 37, 37, 1'b0);
		run_phase(8'h10, 8'h00, 100, 37, 37, 1'b0);
		run_phase(8'h0F, 8'hFF, 200, 37, 37, 1'b0);
		run_phase(8'h03, 8'h05, 250, 37, 37, 1'b0);
		run_phase(8'h02, 8'h02, 200, 0, 0, 1'b1);
		drain();

		if (sb.error_count == 0)
			$display("tb_bitmap_to_page_bytes_top: clean");
		else
			$display("tb_bitmap_to_page_bytes_top: errors");
		$finish;
	end

endmodule
